// ----- hw/rtl/kmc_pkg.sv -----
// shared types, constants and command codes of the hop selector
`default_nettype none
package kmc_pkg;

	localparam int unsigned NeighborsDef = 16;
	localparam int unsigned IdW = 4;
	localparam int unsigned RateW = 32;
	localparam int unsigned DrawW = 32;
	localparam int unsigned DwellW = 40;
	localparam int unsigned StatusW = 2;
	localparam int unsigned CmdW = 3;
	localparam logic [31:0] Ln2Q = 32'd2977044472;
	localparam logic [DwellW-1:0] DwellMax = {DwellW{1'b1}};

	typedef enum logic [CmdW-1:0] {
		CMD_ADD   = 3'd0,
		CMD_SET   = 3'd1,
		CMD_PICK  = 3'd2,
		CMD_DWELL = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_NOPICK  = 2'd3
	} status_t;

	// dwell request and answer between the control and the dwell unit
	typedef struct packed {
		logic        start;
		logic [31:0] draw;
	} dwell_req_t;

	typedef struct packed {
		logic              done;
		logic [DwellW-1:0] value;
	} dwell_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kmc_neg_ln.sv -----
// iterative -ln(u) unit: log2 by repeated squaring, then scale by ln2 and divide
`default_nettype none
module kmc_neg_ln #(
	parameter int unsigned SumW = 36
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kmc_pkg::dwell_req_t req,
	input  wire logic [SumW-1:0]    rate_sum,
	output kmc_pkg::dwell_rsp_t     rsp
);
	import kmc_pkg::*;

	localparam int unsigned NumW = DwellW;

	typedef enum logic [2:0] {
		S_IDLE, S_LOG, S_SQ, S_MULLO, S_MULHI, S_DIV, S_DONE
	} st_t;

	st_t               st_q;
	logic              done_q;
	logic [4:0]        e_q;
	logic [32:0]       m_q;
	logic [29:0]       f_q;
	logic [4:0]        cnt_q;
	logic [37:0]       a_q;
	logic [NumW-1:0]   n_q;
	logic [NumW-1:0]   num_q;
	logic [SumW-1:0]   rem_q;
	logic [5:0]        dcnt_q;
	logic [SumW-1:0]   sum_q;
	logic [DwellW-1:0] res_q;

	logic [65:0]     sq;
	logic [32:0]     sq_sh;
	logic [4:0]      hb;
	logic [31:0]     mul_a;
	logic [63:0]     prod;
	logic [SumW:0]   shifted;
	logic [SumW+1:0] trial;
	logic            qbit;

	// highest set bit of the draw
	always_comb begin
		hb = '0;
		for (int i = 0; i < 32; i++) begin
			if (req.draw[i]) begin
				hb = 5'(i);
			end
		end
	end

	assign sq = m_q * m_q;
	assign sq_sh = sq[63:31];

	// one 32x32 multiplier, low word of the log first, then the high bits
	assign mul_a = (st_q == S_MULLO) ? a_q[31:0] : {26'd0, a_q[37:32]};
	assign prod = {32'd0, mul_a} * {32'd0, Ln2Q};

	// restoring division step: shift in the next dividend bit, then compare
	assign shifted = {rem_q, num_q[NumW-1]};
	assign trial = {1'b0, shifted} - {2'b00, sum_q};
	assign qbit = ~trial[SumW+1];

	assign rsp = {done_q, res_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (req.start) begin
						sum_q <= rate_sum;
						if (req.draw == '0 || rate_sum == '0) begin
							res_q <= DwellMax;
							st_q <= S_DONE;
						end else begin
							e_q <= hb;
							m_q <= {1'b0, req.draw << (5'd31 - hb)};
							f_q <= '0;
							cnt_q <= '0;
							st_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					// one fraction bit per cycle
					if (sq_sh[32]) begin
						m_q <= {1'b0, sq_sh[32:1]};
						f_q <= {f_q[28:0], 1'b1};
					end else begin
						m_q <= sq_sh;
						f_q <= {f_q[28:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd29) begin
						st_q <= S_LOG;
					end
				end
				S_LOG: begin
					// -log2(u) in Q6.30
					a_q <= ({32'd0, 6'(6'd32 - {1'b0, e_q})} << 30) - {8'd0, f_q};
					st_q <= S_MULLO;
				end
				S_MULLO: begin
					n_q <= NumW'(prod[63:32]);
					st_q <= S_MULHI;
				end
				S_MULHI: begin
					// dividend is four times -ln(u)
					num_q <= (n_q + NumW'(prod)) << 2;
					rem_q <= '0;
					dcnt_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit per cycle, quotient shifts into the dividend
					if (qbit) begin
						rem_q <= trial[SumW-1:0];
					end else begin
						rem_q <= shifted[SumW-1:0];
					end
					num_q <= {num_q[NumW-2:0], qbit};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(NumW - 1)) begin
						st_q <= S_DONE;
						res_q <= {num_q[NumW-2:0], qbit};
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/kmc_hop_selector_unit.sv -----
// Hop selector. Holds up to NEIGHBORS slot rates in a one-port synchronous
// memory with a registered read, a valid bit per slot and a running sum.
// One item at a time: add, set and read pass a read step, an update step
// that also writes the memory back, and a result step; unknown codes skip
// the update step. A pick walks the memory one slot a cycle. A dwell draw
// runs in the iterative -ln/divide unit (30 squaring steps, 3 log and
// multiply steps, 40 quotient steps), which skips these steps and returns
// the maximum dwell when the draw or the sum is zero. The next item is
// taken in the cycle after the result leaves, which out_stall can delay.
// No clearing pass: valid bits reset at once.
`default_nettype none
module kmc_hop_selector_unit #(
	parameter int unsigned NEIGHBORS = kmc_pkg::NeighborsDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [kmc_pkg::CmdW-1:0]      cmd,
	input  wire logic [kmc_pkg::IdW-1:0]       neighbor_id,
	input  wire logic [kmc_pkg::RateW-1:0]     rate_value,
	input  wire logic [kmc_pkg::DrawW-1:0]     uniform_draw,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [kmc_pkg::StatusW-1:0]        status,
	output logic [kmc_pkg::IdW-1:0]            chosen_id,
	output logic [kmc_pkg::DwellW-1:0]         dwell_time,
	output logic [kmc_pkg::RateW-1:0]          rate_out
);
	import kmc_pkg::*;

	localparam int unsigned AW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam int unsigned SumW = RateW + AW;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_UPD, S_WALK, S_DWELL, S_OUT} st_t;

	st_t             st_q;
	logic [RateW-1:0] mem [NEIGHBORS];
	logic [RateW-1:0] rdata_q;
	logic [NEIGHBORS-1:0] valid_q;
	logic [SumW-1:0] sum_q;
	cmd_t            cmd_q;
	logic [AW-1:0]   id_q;
	logic            inr_q;
	logic [RateW-1:0] rate_q;
	logic [DrawW-1:0] draw_q;
	logic [AW:0]     walk_q;
	logic [SumW-1:0] cum_q;
	logic [SumW-1:0] t_q;
	logic            found_q;
	logic [AW-1:0]   pick_q;
	logic            wr_en;
	logic [AW-1:0]   rd_addr;
	dwell_req_t      dreq;
	dwell_rsp_t      drsp;
	logic [SumW+DrawW-1:0] tprod;
	logic [SumW-1:0] cum_next;

	assign in_stall = (st_q != S_IDLE);
	assign tprod = sum_q * draw_q;
	assign wr_en = (st_q == S_UPD) && inr_q && (cmd_q == CMD_SET ||
		(cmd_q == CMD_ADD && !valid_q[id_q]));
	// a pick reads slot 0 already in S_RD, then one slot ahead of the walk
	assign rd_addr = (cmd_q == CMD_PICK) ? walk_q[AW-1:0] : id_q;
	assign cum_next = cum_q + SumW'(rdata_q);

	// rate memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[id_q] <= rate_q;
		end
		rdata_q <= mem[rd_addr];
	end

	assign dreq = {(st_q == S_RD) && (cmd_q == CMD_DWELL), draw_q};

	kmc_neg_ln #(.SumW(SumW)) u_ln (
		.clk(clk), .arst_n(arst_n), .req(dreq), .rate_sum(sum_q), .rsp(drsp)
	);

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			valid_q <= '0;
			sum_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd_t'(cmd);
						id_q <= AW'(neighbor_id);
						inr_q <= ({28'd0, neighbor_id} < NEIGHBORS);
						rate_q <= rate_value;
						draw_q <= uniform_draw;
						walk_q <= '0;
						st_q <= S_RD;
					end
				end
				S_RD: begin
					status <= ST_OK;
					chosen_id <= '0;
					dwell_time <= '0;
					rate_out <= '0;
					cum_q <= '0;
					found_q <= 1'b0;
					pick_q <= '0;
					t_q <= SumW'(tprod >> DrawW);
					priority case (1'b1)
						(cmd_q == CMD_PICK): begin
							walk_q <= walk_q + 1'b1;
							st_q <= S_WALK;
						end
						(cmd_q == CMD_DWELL): st_q <= S_DWELL;
						(cmd_q == CMD_ADD || cmd_q == CMD_SET || cmd_q == CMD_READ):
							st_q <= S_UPD;
						default: st_q <= S_OUT;
					endcase
				end
				S_UPD: begin
					if (!inr_q) begin
						status <= ST_ABSENT;
					end else if (cmd_q == CMD_ADD) begin
						if (valid_q[id_q]) begin
							status <= ST_PRESENT;
						end else begin
							valid_q[id_q] <= 1'b1;
							sum_q <= sum_q + SumW'(rate_q);
						end
					end else if (cmd_q == CMD_SET) begin
						valid_q[id_q] <= 1'b1;
						sum_q <= sum_q + SumW'(rate_q)
							- (valid_q[id_q] ? SumW'(rdata_q) : '0);
					end else if (valid_q[id_q]) begin
						rate_out <= rdata_q;
					end else begin
						status <= ST_ABSENT;
					end
					st_q <= S_OUT;
				end
				S_WALK: begin
					// rdata_q holds slot walk_q-1
					if (!found_q && valid_q[AW'(walk_q - 1'b1)]) begin
						cum_q <= cum_next;
						if (t_q < cum_next) begin
							found_q <= 1'b1;
							pick_q <= AW'(walk_q - 1'b1);
						end
					end
					if (walk_q == (AW+1)'(NEIGHBORS)) begin
						st_q <= S_OUT;
						if (!found_q && !(valid_q[AW'(walk_q - 1'b1)]
							&& t_q < cum_next)) begin
							status <= ST_NOPICK;
						end else if (!found_q) begin
							chosen_id <= IdW'(AW'(walk_q - 1'b1));
						end else begin
							chosen_id <= IdW'(pick_q);
						end
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				S_DWELL: begin
					if (drsp.done) begin
						dwell_time <= drsp.value;
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
